// File: rtl/core/u8wd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to wide character decoder package
// Shared types, register indexes, lead byte classes and class offsets.
// ----------------------------------------------------------------------------
package u8wd_pkg;

  localparam int COUNT_BITS = 16;

  localparam logic CFG_OUTPUT_FORM = 1'b0;
  localparam logic CFG_UNIT_LIMIT  = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] unit_value;
    logic        end_mark;
    logic [15:0] units_written;
    logic        limit_hit;
  } out_item_t;

  typedef struct packed {
    logic      take;
    logic      v0;
    logic      v1;
    out_item_t u0;
    out_item_t u1;
  } res_bundle_t;

  function automatic logic [2:0] lead_class(input logic [7:0] b);
    logic [2:0] cls;
    begin
      cls = 3'd0;
      if (b inside {[8'hC0 : 8'hDF]}) begin
        cls = 3'd1;
      end else if (b inside {[8'hE0 : 8'hEF]}) begin
        cls = 3'd2;
      end else if (b inside {[8'hF0 : 8'hF7]}) begin
        cls = 3'd3;
      end else if (b inside {[8'hF8 : 8'hFB]}) begin
        cls = 3'd4;
      end else if (b inside {[8'hFC : 8'hFF]}) begin
        cls = 3'd5;
      end
      return cls;
    end
  endfunction

  function automatic logic [31:0] class_offset(input logic [2:0] cls);
    logic [31:0] off;
    begin
      case (cls)
        3'd1: begin
          off = 32'h0000_3080;
        end
        3'd2: begin
          off = 32'h000E_2080;
        end
        3'd3: begin
          off = 32'h03C8_2080;
        end
        3'd4: begin
          off = 32'hFA08_2080;
        end
        3'd5: begin
          off = 32'h8208_2080;
        end
        default: begin
          off = 32'h0000_0000;
        end
      endcase
      return off;
    end
  endfunction

endpackage

// File: rtl/core/u8wd_if.sv
// ----------------------------------------------------------------------------
// UTF-8 to wide character decoder channels
// Valid/ready request channels for input bytes and output code units.
// ----------------------------------------------------------------------------
interface u8wd_in_if;
  logic               valid;
  logic               ready;
  u8wd_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface u8wd_out_if;
  logic                valid;
  logic                ready;
  u8wd_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/u8wd_core.sv
// ----------------------------------------------------------------------------
// UTF-8 to wide character decoder core
// Input register, configuration, decode state and per-byte result logic.
// ----------------------------------------------------------------------------
module u8wd_core #(
  parameter int COUNT_BITS = u8wd_pkg::COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  space_i,
  u8wd_in_if.sink               in_req,
  output u8wd_pkg::res_bundle_t res_o
);

  logic                  form_q;
  logic [15:0]           limit_q;
  logic                  a_valid_q;
  u8wd_pkg::in_item_t    a_item_q;
  logic [31:0]           acc_q, acc_d;
  logic [2:0]            trail_q, trail_d;
  logic [2:0]            cls_q, cls_d;
  logic [15:0]           rem_q, rem_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic                  take;

  assign take         = a_valid_q && space_i;
  assign in_req.ready = !a_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      form_q  <= 1'b0;
      limit_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        u8wd_pkg::CFG_OUTPUT_FORM: begin
          form_q <= cfg_data_i[0];
        end
        u8wd_pkg::CFG_UNIT_LIMIT: begin
          limit_q <= cfg_data_i;
        end
        default: begin
          form_q <= form_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_req.ready) begin
      a_valid_q <= in_req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req.ready && in_req.valid) begin
      a_item_q <= in_req.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= 32'd0;
      trail_q <= 3'd0;
      cls_q   <= 3'd0;
      rem_q   <= 16'd0;
      cnt_q   <= '0;
      done_q  <= 1'b1;
    end else begin
      acc_q   <= acc_d;
      trail_q <= trail_d;
      cls_q   <= cls_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    logic                  live;
    logic [2:0]            trail_eff;
    logic [31:0]           cp;
    logic [31:0]           dd;
    logic [15:0]           hi;
    logic [15:0]           lo;
    logic                  single;
    logic                  hit1;
    logic                  hit2;
    logic [COUNT_BITS-1:0] cnt1;
    logic [15:0]           rem1;

    acc_d     = acc_q;
    trail_d   = trail_q;
    cls_d     = cls_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    done_d    = done_q;
    res_o     = '0;
    res_o.take = take;
    live      = a_item_q.first_byte || !done_q;
    trail_eff = trail_q;
    cp        = 32'd0;
    dd        = 32'd0;
    hi        = 16'd0;
    lo        = 16'd0;
    single    = 1'b1;
    hit1      = 1'b0;
    hit2      = 1'b0;
    cnt1      = '0;
    rem1      = 16'd0;

    if (take && live) begin
      if (a_item_q.first_byte) begin
        done_d    = 1'b0;
        cnt_d     = '0;
        rem_d     = limit_q;
        trail_eff = 3'd0;
      end
      if (trail_eff == 3'd0) begin
        cls_d   = u8wd_pkg::lead_class(a_item_q.in_byte);
        trail_d = cls_d;
        acc_d   = {24'd0, a_item_q.in_byte};
      end else begin
        acc_d   = {acc_q[25:0], 6'd0} + {24'd0, a_item_q.in_byte};
        trail_d = trail_eff - 3'd1;
      end
      if (trail_d == 3'd0) begin
        cp = acc_d - u8wd_pkg::class_offset(cls_d);
        if (cp == 32'd0) begin
          done_d   = 1'b1;
          res_o.v0 = 1'b1;
          res_o.u0 = '{unit_value: 32'd0, end_mark: 1'b1,
                       units_written: 16'(cnt_d), limit_hit: 1'b0};
        end else begin
          single = form_q || (cp[31:16] == 16'd0);
          dd     = cp - 32'h0001_0000;
          hi     = dd[25:10] + 16'hD800;
          lo     = {6'b110111, dd[9:0]};
          cnt1   = cnt_d + COUNT_BITS'(1);
          hit1   = (rem_d == 16'd1);
          rem1   = (rem_d != 16'd0) ? rem_d - 16'd1 : 16'd0;
          res_o.v0 = 1'b1;
          res_o.u0 = '{unit_value: single ? cp : {16'd0, hi}, end_mark: hit1,
                       units_written: 16'(cnt1), limit_hit: hit1};
          cnt_d  = cnt1;
          rem_d  = rem1;
          if (hit1) begin
            done_d = 1'b1;
          end else if (!single) begin
            hit2     = (rem1 == 16'd1);
            cnt_d    = cnt1 + COUNT_BITS'(1);
            rem_d    = (rem1 != 16'd0) ? rem1 - 16'd1 : 16'd0;
            res_o.v1 = 1'b1;
            res_o.u1 = '{unit_value: {16'd0, lo}, end_mark: hit2,
                         units_written: 16'(cnt_d), limit_hit: hit2};
            if (hit2) begin
              done_d = 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/u8wd_outq.sv
// ----------------------------------------------------------------------------
// UTF-8 to wide character decoder result queue
// Two-entry result register that holds one or two code units per request.
// ----------------------------------------------------------------------------
module u8wd_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  u8wd_pkg::res_bundle_t res_i,
  output logic                  space_o,
  u8wd_out_if.source            out_req
);

  logic [1:0]          cnt_q, cnt_d;
  u8wd_pkg::out_item_t slot0_q, slot0_d;
  u8wd_pkg::out_item_t slot1_q, slot1_d;
  logic                pop;

  assign pop             = out_req.valid && out_req.ready;
  assign out_req.valid   = (cnt_q != 2'd0);
  assign out_req.payload = slot0_q;
  assign space_o         = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (res_i.take) begin
      slot0_d = res_i.u0;
      slot1_d = res_i.u1;
      cnt_d   = {res_i.v1, res_i.v0 && !res_i.v1};
    end else if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

// File: rtl/core/utf8_to_wide_char_decoder_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 to wide character decoder
// Decodes a UTF-8 byte stream into UTF-16 or UTF-32 code units.
// ----------------------------------------------------------------------------
// A completing byte is held in the input register, then its code unit is
// registered in the result queue. Throughput: one byte per cycle unless the
// output stalls; a surrogate pair fills both slots, so the next byte waits.
// Reset is asynchronous and active low; the decoder is then idle until a
// byte marked as the first of a string arrives.
module utf8_to_wide_char_decoder_unit #(
  parameter int COUNT_BITS = u8wd_pkg::COUNT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  u8wd_in_if.sink     in_req_i,
  u8wd_out_if.source  out_req_o
);

  u8wd_pkg::res_bundle_t res;
  logic                  space;

  u8wd_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .space_i    (space),
    .in_req     (in_req_i),
    .res_o      (res)
  );

  u8wd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .space_o (space),
    .out_req (out_req_o)
  );

  ap_stall_only_on_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_req_i.ready |-> out_req_o.valid)
    else $error("input stalled with no result pending");

  ap_hit_ends_string : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_req_o.valid && out_req_o.payload.limit_hit |-> out_req_o.payload.end_mark)
    else $error("limit hit without end mark");

  ap_second_only_after_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.v1 |-> res.v0 && res.take)
    else $error("second unit without first");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// UTF-8 to wide character decoder testbench
// Feeds UTF-8 strings through the request channel under several settings of
// the output form and the unit limit. A predictor in the scoreboard keeps its
// own copy of the decoder state. Every returned code unit is checked, field by
// field, against the oldest unit still due. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT     = 28;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 125;
  localparam int NUM_PHASES   = 10;
  localparam int LONG_RUN     = 120;

  class unit_predictor;
    u8wd_pkg::out_item_t             units_due[$];
    logic [31:0]                     acc;
    logic [2:0]                      trail;
    logic [2:0]                      seq_class;
    logic [15:0]                     room;
    logic [u8wd_pkg::COUNT_BITS-1:0] count;
    bit                              done;
    bit                              form;
    logic [15:0]                     limit;
    int                              errors;

    function new();
      acc       = '0;
      trail     = '0;
      seq_class = '0;
      room      = '0;
      count     = '0;
      done      = 1'b1;
      form      = 1'b0;
      limit     = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == u8wd_pkg::CFG_OUTPUT_FORM) begin
        form = data[0];
      end else begin
        limit = data;
      end
    endfunction

    function void push_unit(logic [31:0] value, bit fin, bit hit);
      u8wd_pkg::out_item_t u;
      u.unit_value    = value;
      u.end_mark      = fin;
      u.units_written = 16'(count);
      u.limit_hit     = hit;
      units_due.push_back(u);
    endfunction

    function bit count_unit(logic [31:0] value);
      bit hit;
      hit   = 1'b0;
      count = count + 1'b1;
      if (room != 0) begin
        room = room - 1'b1;
        if (room == 0) begin
          hit  = 1'b1;
          done = 1'b1;
        end
      end
      push_unit(value, hit, hit);
      return hit;
    endfunction

    function void note_request(u8wd_pkg::in_item_t req);
      logic [31:0] cp;
      logic [31:0] d;
      logic [31:0] bias;
      if (req.first_byte) begin
        done  = 1'b0;
        count = '0;
        room  = limit;
        trail = '0;
      end else if (done) begin
        return;
      end
      if (trail == 0) begin
        if (req.in_byte < 8'hC0) begin
          seq_class = 3'd0;
        end else if (req.in_byte < 8'hE0) begin
          seq_class = 3'd1;
        end else if (req.in_byte < 8'hF0) begin
          seq_class = 3'd2;
        end else if (req.in_byte < 8'hF8) begin
          seq_class = 3'd3;
        end else if (req.in_byte < 8'hFC) begin
          seq_class = 3'd4;
        end else begin
          seq_class = 3'd5;
        end
        trail = seq_class;
        acc   = {24'd0, req.in_byte};
      end else begin
        acc   = (acc << 6) + {24'd0, req.in_byte};
        trail = trail - 1'b1;
      end
      if (trail != 0) begin
        return;
      end
      case (seq_class)
        3'd1: begin
          bias = 32'h0000_3080;
        end
        3'd2: begin
          bias = 32'h000E_2080;
        end
        3'd3: begin
          bias = 32'h03C8_2080;
        end
        3'd4: begin
          bias = 32'hFA08_2080;
        end
        3'd5: begin
          bias = 32'h8208_2080;
        end
        default: begin
          bias = 32'h0;
        end
      endcase
      cp = acc - bias;
      if (cp == 0) begin
        done = 1'b1;
        push_unit(32'h0, 1'b1, 1'b0);
      end else if (form || cp <= 32'hFFFF) begin
        void'(count_unit(cp));
      end else begin
        d = cp - 32'h1_0000;
        if (!count_unit(((d >> 10) + 32'hD800) & 32'hFFFF)) begin
          void'(count_unit((d & 32'h3FF) + 32'hDC00));
        end
      end
    endfunction

    function void check_unit(u8wd_pkg::out_item_t got);
      u8wd_pkg::out_item_t want;
      if (units_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Unexpected unit: value %h end %b count %0d limit %b",
                   got.unit_value, got.end_mark, got.units_written, got.limit_hit);
        end
        return;
      end
      want = units_due.pop_front();
      if (got.unit_value !== want.unit_value || got.end_mark !== want.end_mark ||
          got.units_written !== want.units_written || got.limit_hit !== want.limit_hit) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Unit mismatch: expected value %h end %b count %0d limit %b",
                   want.unit_value, want.end_mark, want.units_written, want.limit_hit);
          $display("               actual   value %h end %b count %0d limit %b",
                   got.unit_value, got.end_mark, got.units_written, got.limit_hit);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;

  unit_predictor sb = new();

  u8wd_in_if  in_ch ();
  u8wd_out_if out_ch ();

  utf8_to_wide_char_decoder_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req_i   (in_ch),
    .out_req_o  (out_ch)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_request(in_ch.payload);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_unit(out_ch.payload);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(u8wd_pkg::in_item_t req);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= req;
    @(posedge clk_i);
    while (!in_ch.ready) begin
      @(posedge clk_i);
    end
    requests_sent++;
  endtask

  task automatic send_byte(logic [7:0] b, bit first);
    u8wd_pkg::in_item_t req;
    req.in_byte    = b;
    req.first_byte = first;
    send_item(req);
  endtask

  // Encodes cp in n bytes but sends only keep of its trailing bytes.
  task automatic send_char(logic [31:0] cp, int n, int keep, bit first);
    logic [7:0] prefix;
    logic [7:0] mask;
    if (n == 1) begin
      prefix = 8'h00;
      mask   = 8'h7F;
    end else begin
      prefix = 8'hFF << (8 - n);
      mask   = 8'hFF >> (n + 1);
    end
    send_byte(prefix | (8'(cp >> (6 * (n - 1))) & mask), first);
    for (int k = 1; k <= keep; k++) begin
      send_byte(8'h80 | (8'(cp >> (6 * (n - 1 - k))) & 8'h3F), 1'b0);
    end
  endtask

  task automatic send_random_string(int nchars);
    int          kind;
    int          r;
    int          n;
    logic [31:0] cp;
    for (int i = 0; i < nchars; i++) begin
      kind = $urandom_range(99);
      r    = $urandom_range(99);
      n    = (r < 40) ? 1 : (r < 55) ? 2 : (r < 70) ? 3 : (r < 90) ? 4 : (r < 95) ? 5 : 6;
      cp   = $urandom() & ((n == 1) ? 32'h7F : ((32'd1 << (5 * n + 1)) - 1));
      if (kind < 82) begin
        send_char(cp, n, n - 1, i == 0);
      end else if (kind < 88) begin
        send_char(cp, n, $urandom_range(n - 1), i == 0);
      end else if (kind < 95) begin
        send_byte(8'($urandom_range(255)), i == 0);
      end else begin
        send_char(cp, n, n - 1, 1'b1);
      end
    end
    kind = $urandom_range(99);
    if (kind < 70) begin
      send_byte(8'h00, 1'b0);
    end else if (kind < 90) begin
      n = $urandom_range(2, 6);
      send_char(32'h0, n, n - 1, 1'b0);
    end
    repeat ($urandom_range(2)) begin
      send_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.units_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  bit          phase_form [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                                           1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  logic [15:0] phase_limit[NUM_PHASES] = '{16'd3, 16'd0, 16'd0, 16'd1, 16'd1,
                                           16'd2, 16'd5, 16'hFFFF, 16'hFFFF, 16'd7};

  initial begin
    int unsigned target;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = u8wd_pkg::CFG_OUTPUT_FORM;
    cfg_data_i    = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(u8wd_pkg::CFG_OUTPUT_FORM, 16'd0);
    write_reg(u8wd_pkg::CFG_UNIT_LIMIT, 16'd0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b1);
    send_char(32'h80, 2, 1, 1'b0);
    send_char(32'hFFFF, 3, 2, 1'b0);
    send_char(32'h1_0000, 4, 3, 1'b0);
    send_char(32'h7FFF_FFFF, 6, 5, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_char(32'h0, 2, 1, 1'b1);
    send_byte(8'h00, 1'b0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p == 2);
      write_reg(u8wd_pkg::CFG_OUTPUT_FORM, {15'd0, phase_form[p]});
      write_reg(u8wd_pkg::CFG_UNIT_LIMIT, phase_limit[p]);
      if (!phase_form[p] && phase_limit[p] != 0 && phase_limit[p] <= 8) begin
        for (int k = 1; k < phase_limit[p]; k++) begin
          send_byte(8'h40 + 8'(k), k == 1);
        end
        send_char(32'h1_F600, 4, 3, phase_limit[p] == 1);
        send_byte(8'h43, 1'b0);
      end
      target = requests_sent + PHASE_ITEMS;
      while (requests_sent < target) begin
        send_random_string($urandom_range(1, 12));
      end
      drain();
    end

    // One unlimited string in UTF-32 form with no idling on either side.
    calm = 1'b1;
    write_reg(u8wd_pkg::CFG_OUTPUT_FORM, 16'd1);
    write_reg(u8wd_pkg::CFG_UNIT_LIMIT, 16'd0);
    send_byte(8'h31, 1'b1);
    repeat (LONG_RUN) begin
      send_byte(8'($urandom_range(1, 127)), 1'b0);
    end
    send_byte(8'h00, 1'b0);
    drain();

    if (sb.errors == 0 && sb.units_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
